// ----- design/ccenc_pkg.sv -----
// Shared types, constants and the BCH(63,56) remainder update for the CLTU encoder.
// No dependencies; every other design file refers to this package by scoped names.
package ccenc_pkg;

    localparam logic [6:0] BCH_POLY   = 7'h45;
    localparam logic [7:0] FILL_BYTE  = 8'h55;
    localparam logic [7:0] TAIL_A     = 8'hC5;
    localparam logic [7:0] TAIL_A_END = 8'h79;
    localparam logic [7:0] START_HI   = 8'hEB;
    localparam logic [7:0] START_LO   = 8'h90;

    localparam logic [2:0] BLOCK_LAST_POS = 3'd6;
    localparam logic [2:0] TAIL_LAST_IDX  = 3'd7;
    localparam logic       TAIL_MODE_RESET = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ccenc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       cltu_end;
    } ccenc_out_t;

    typedef enum logic [2:0] {
        PH_START_HI,
        PH_START_LO,
        PH_DATA,
        PH_PARITY,
        PH_FILL,
        PH_TAIL
    } ccenc_phase_t;

    // Shift one byte, MSB first, through the remainder register.
    function automatic logic [6:0] bch_update(input logic [6:0] par, input logic [7:0] b);
        logic [6:0] p;
        logic       fb;
        p = par;
        for (int k = 7; k >= 0; k--) begin
            fb = p[6] ^ b[k];
            p  = {p[5:0], 1'b0};
            if (fb)
            begin
                p = p ^ BCH_POLY;
            end
        end
        return p;
    endfunction

endpackage

// ----- design/ccenc_in_reg.sv -----
// Input holding register for the CLTU encoder: keeps one item until the sequencer is done.
// Depends on ccenc_pkg for the input item type.
module ccenc_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ccenc_pkg::ccenc_in_t in_data,
    input  logic                 consume,
    output logic                 hold_valid,
    output ccenc_pkg::ccenc_in_t hold_data
);

    logic                 valid_reg;
    logic                 valid_next;
    ccenc_pkg::ccenc_in_t data_reg;
    logic                 take;

    // Free slot, or the held item finishes in this cycle.
    assign in_stall   = valid_reg && !consume;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= in_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

// ----- design/ccenc_seq.sv -----
// CLTU byte sequencer: start, data, parity, fill and tail bytes, one a cycle unless stalled.
// Depends on ccenc_pkg for types, constants and the BCH update function.
module ccenc_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hold_valid,
    input  ccenc_pkg::ccenc_in_t  hold_data,
    input  logic                  advance,
    input  logic                  tail_mode,
    output logic                  emit_valid,
    output ccenc_pkg::ccenc_out_t emit_data,
    output logic                  consume
);

    ccenc_pkg::ccenc_phase_t phase_reg;
    ccenc_pkg::ccenc_phase_t phase_next;
    logic [6:0]              parity_reg;
    logic [6:0]              parity_next;
    logic [2:0]              block_pos_reg;
    logic [2:0]              block_pos_next;
    logic [2:0]              tail_cnt_reg;
    logic [2:0]              tail_cnt_next;
    logic                    done;
    logic                    step;
    logic [6:0]              par_coded;

    assign step       = hold_valid && advance;
    assign emit_valid = hold_valid;
    assign consume    = step && done;

    assign par_coded = ccenc_pkg::bch_update(parity_reg,
        (phase_reg == ccenc_pkg::PH_FILL) ? ccenc_pkg::FILL_BYTE : hold_data.data_byte);

    // Next-state logic
    always_comb
    begin
        phase_next     = phase_reg;
        parity_next    = parity_reg;
        block_pos_next = block_pos_reg;
        tail_cnt_next  = tail_cnt_reg;
        unique case (phase_reg) inside
            ccenc_pkg::PH_START_HI: phase_next = ccenc_pkg::PH_START_LO;
            ccenc_pkg::PH_START_LO: phase_next = ccenc_pkg::PH_DATA;
            ccenc_pkg::PH_DATA, ccenc_pkg::PH_FILL:
            begin
                parity_next = par_coded;
                if (block_pos_reg == ccenc_pkg::BLOCK_LAST_POS)
                begin
                    block_pos_next = '0;
                    phase_next     = ccenc_pkg::PH_PARITY;
                end
                else
                begin
                    block_pos_next = block_pos_reg + 3'd1;
                    phase_next     = hold_data.last_byte ? ccenc_pkg::PH_FILL
                                                         : ccenc_pkg::PH_DATA;
                end
            end
            ccenc_pkg::PH_PARITY:
            begin
                parity_next   = '0;
                tail_cnt_next = '0;
                phase_next    = hold_data.last_byte ? ccenc_pkg::PH_TAIL
                                                    : ccenc_pkg::PH_DATA;
            end
            ccenc_pkg::PH_TAIL:
            begin
                tail_cnt_next = tail_cnt_reg + 3'd1;
                if (tail_cnt_reg == ccenc_pkg::TAIL_LAST_IDX)
                begin
                    phase_next = ccenc_pkg::PH_START_HI;
                end
            end
            default: phase_next = ccenc_pkg::PH_START_HI;
        endcase
    end

    // Output logic
    always_comb
    begin
        emit_data = '0;
        done      = 1'b0;
        unique case (phase_reg)
            ccenc_pkg::PH_START_HI: emit_data.out_byte = ccenc_pkg::START_HI;
            ccenc_pkg::PH_START_LO: emit_data.out_byte = ccenc_pkg::START_LO;
            ccenc_pkg::PH_DATA:
            begin
                emit_data.out_byte = hold_data.data_byte;
                done = !hold_data.last_byte && (block_pos_reg != ccenc_pkg::BLOCK_LAST_POS);
            end
            ccenc_pkg::PH_FILL: emit_data.out_byte = ccenc_pkg::FILL_BYTE;
            ccenc_pkg::PH_PARITY:
            begin
                emit_data.out_byte = {~parity_reg, 1'b0};
                done = !hold_data.last_byte;
            end
            ccenc_pkg::PH_TAIL:
            begin
                if (tail_mode)
                begin
                    emit_data.out_byte = ccenc_pkg::FILL_BYTE;
                end
                else if (tail_cnt_reg == ccenc_pkg::TAIL_LAST_IDX)
                begin
                    emit_data.out_byte = ccenc_pkg::TAIL_A_END;
                end
                else
                begin
                    emit_data.out_byte = ccenc_pkg::TAIL_A;
                end
                emit_data.cltu_end = (tail_cnt_reg == ccenc_pkg::TAIL_LAST_IDX);
                done = (tail_cnt_reg == ccenc_pkg::TAIL_LAST_IDX);
            end
            default: emit_data.out_byte = '0;
        endcase
        emit_data.run_last = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ccenc_pkg::PH_START_HI;
            parity_reg    <= '0;
            block_pos_reg <= '0;
            tail_cnt_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            parity_reg    <= parity_next;
            block_pos_reg <= block_pos_next;
            tail_cnt_reg  <= tail_cnt_next;
        end
    end

endmodule

// ----- design/ccenc_out_reg.sv -----
// Output register for the CLTU encoder: holds one result item while the receiver stalls.
// Depends on ccenc_pkg for the result item type.
module ccenc_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  ccenc_pkg::ccenc_out_t load_data,
    output logic                  advance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ccenc_pkg::ccenc_out_t out_data
);

    logic                  valid_reg;
    logic                  valid_next;
    ccenc_pkg::ccenc_out_t data_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/ccenc_top.sv -----
// CLTU encoder top level: input register, byte sequencer, output register, tail mode register.
// Depends on ccenc_pkg, ccenc_in_reg, ccenc_seq and ccenc_out_reg.
//
// Usage:
//   Feed a telecommand frame one data byte per item on the input channel
//   (in_valid / in_stall / in_data), with last_byte set on its final byte.
//   CLTU bytes leave on the output channel (out_valid / out_stall / out_data),
//   one byte per cycle unless the receiver stalls: EB 90 before the first byte of a frame,
//   each data byte, a parity byte after every seventh byte of a code block, 55 fill bytes
//   to close a partial block on the last byte, then eight tail bytes.
//   run_last flags the final result of each item, cltu_end the final tail byte.
//   cfg_wr_en / cfg_wr_data write tail_mode (0: C5 x7 then 79, 1: 55 x8);
//   write it only while the block is idle.
// Timing:
//   An item is taken into the input register, and its first result is then
//   registered in the output register. The sequencer emits one byte per cycle
//   while the receiver does not stall; an item has 1 result for a plain data
//   byte, +1 for a parity byte, +2 for a frame start, up to 18 for a one-byte
//   frame. The next item is accepted in the cycle the current one emits its
//   last byte. The output port, at one byte per cycle when not stalled, sets this.
// Reset and stall:
//   Reset empties both registers and waits for the start of a frame. While the
//   receiver stalls, the output item holds and the sequencer and input freeze.
module ccsds_cltu_encoder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ccenc_pkg::ccenc_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ccenc_pkg::ccenc_out_t out_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data
);

    logic                  hold_valid;
    ccenc_pkg::ccenc_in_t  hold_data;
    logic                  consume;
    logic                  advance;
    logic                  emit_valid;
    ccenc_pkg::ccenc_out_t emit_data;
    logic                  tail_mode_reg;

    // Tail selection, sampled by the sequencer while it emits the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_mode_reg <= ccenc_pkg::TAIL_MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            tail_mode_reg <= cfg_wr_data;
        end
    end

    // Hold the current item until its last byte is emitted.
    ccenc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .consume    (consume),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    // Advance one CLTU byte per cycle whenever the output register can load.
    ccenc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .advance    (advance),
        .tail_mode  (tail_mode_reg),
        .emit_valid (emit_valid),
        .emit_data  (emit_data),
        .consume    (consume)
    );

    // Separate the sequencer from the receiver.
    ccenc_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (emit_valid),
        .load_data  (emit_data),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ----- tb/sv/ccsds_cltu_encoder_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CLTU encoder: frames in, CLTU bytes out, BCH(63,56) parity.
// Depends on ccenc_pkg and ccsds_cltu_encoder_top; predicts every byte in its own model.
module ccsds_cltu_encoder_top_test;

    // Tail mode register values.
    localparam logic TAIL_C5_79 = 1'b0;
    localparam logic TAIL_55    = 1'b1;

    // Cycles to wait after the last expected byte: one item never causes more than 18 bytes.
    localparam int SETTLE_CYCLES = 24;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    ccenc_pkg::ccenc_in_t  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    ccenc_pkg::ccenc_out_t out_data;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_wr_data = 1'b0;

    // Encoder shadow state, kept in step with every accepted item.
    logic       tail_sel = TAIL_C5_79;
    logic [6:0] bch_rem = '0;
    int         block_fill = 0;
    logic       frame_open = 1'b0;

    ccenc_pkg::ccenc_out_t cltu_bytes_due[$];
    int                    mismatches = 0;

    // Idle rates in percent, and the length of a forced receiver hold-off.
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    ccsds_cltu_encoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void push_cltu_byte(input logic [7:0] b, input logic cltu_last);
        ccenc_pkg::ccenc_out_t r;
        r.out_byte = b;
        r.run_last = 1'b0;
        r.cltu_end = cltu_last;
        cltu_bytes_due.push_back(r);
    endfunction

    // Emit one code block byte, fold it MSB first into the remainder, and close the
    // block with the inverted remainder and a zero filler bit after its seventh byte.
    function automatic void code_block_byte(input logic [7:0] b);
        logic fb;
        push_cltu_byte(b, 1'b0);
        for (int k = 7; k >= 0; k--)
        begin
            fb = bch_rem[6] ^ b[k];
            bch_rem = {bch_rem[5:0], 1'b0};
            if (fb)
            begin
                bch_rem = bch_rem ^ ccenc_pkg::BCH_POLY;
            end
        end
        block_fill++;
        if (block_fill == 7)
        begin
            push_cltu_byte({~bch_rem, 1'b0}, 1'b0);
            bch_rem = '0;
            block_fill = 0;
        end
    endfunction

    // Work out every CLTU byte that one accepted item causes.
    function automatic void encode_item(input ccenc_pkg::ccenc_in_t item);
        if (!frame_open)
        begin
            push_cltu_byte(ccenc_pkg::START_HI, 1'b0);
            push_cltu_byte(ccenc_pkg::START_LO, 1'b0);
            frame_open = 1'b1;
        end
        code_block_byte(item.data_byte);
        if (item.last_byte)
        begin
            // Pad the partial block with fill bytes, which are coded as well.
            while (block_fill != 0)
            begin
                code_block_byte(ccenc_pkg::FILL_BYTE);
            end
            for (int i = 0; i < 7; i++)
            begin
                push_cltu_byte((tail_sel == TAIL_55) ? ccenc_pkg::FILL_BYTE
                                                     : ccenc_pkg::TAIL_A, 1'b0);
            end
            push_cltu_byte((tail_sel == TAIL_55) ? ccenc_pkg::FILL_BYTE
                                                 : ccenc_pkg::TAIL_A_END, 1'b1);
            bch_rem = '0;
            block_fill = 0;
            frame_open = 1'b0;
        end
        // Every item causes at least one byte, so the newest entry belongs to it.
        cltu_bytes_due[cltu_bytes_due.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item, idling first at the current rate. Returns in the time step of
    // the accepting edge with valid still high; the caller either offers the next
    // item or drops valid in that same step, never both.
    task automatic send_byte(input logic [7:0] b, input logic last);
        ccenc_pkg::ccenc_in_t item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.data_byte = b;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_data  <= item;
        // in_stall is read before this edge's updates land, so this is the value
        // that the block saw when it decided to take the item.
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        encode_item(item);
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Drop valid and hold until every predicted byte has come out, then let the
    // block go quiet.
    task automatic drain_cltu();
        in_valid <= 1'b0;
        while (cltu_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the tail mode register; call only after drain_cltu.
    task automatic write_tail_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tail_sel = mode;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, or a forced hold-off while hold_left runs down
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted byte against the oldest prediction.
    always @(posedge clk)
    begin
        ccenc_pkg::ccenc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cltu_bytes_due.size() == 0)
            begin
                $error("CLTU byte %h with nothing expected", out_data.out_byte);
                mismatches++;
            end
            else
            begin
                want = cltu_bytes_due.pop_front();
                if (out_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
                    mismatches++;
                end
                if (out_data.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, out_data.run_last);
                    mismatches++;
                end
                if (out_data.cltu_end !== want.cltu_end)
                begin
                    $error("cltu_end: expected %b, got %b", want.cltu_end, out_data.cltu_end);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-byte frames at both byte extremes (the most bytes a single item can
    // cause), an exact seven-byte block with no fill, and eight bytes, which
    // spill one byte into a second block padded with six fill bytes.
    task automatic test_directed_frames();
        send_idle_pct = 0;
        stall_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hAA, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'h11 << (i % 4), i == 7);
        end
        drain_cltu();
    endtask

    // Switch to the all-fill tail and back, with short frames in each.
    task automatic test_tail_modes();
        write_tail_mode(TAIL_55);
        send_byte(8'h55, 1'b1);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h79, 1'b1);
        drain_cltu();
        write_tail_mode(TAIL_C5_79);
        send_byte(8'hEB, 1'b1);
        drain_cltu();
    endtask

    // Random frames, mostly short, a few spanning several code blocks.
    task automatic test_random_frames(input int idle, input int stall, input int n_items,
                                      input logic mode);
        int sent;
        int len;
        write_tail_mode(mode);
        send_idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                len = 1;
            end
            else if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(2, 14);
            end
            else
            begin
                len = $urandom_range(15, 30);
            end
            send_frame(len);
            sent += len;
        end
        drain_cltu();
    endtask

    // Hold the receiver off long enough that the block backs up and stalls its
    // input while a frame keeps coming; then pause the sender mid-frame until
    // every byte so far has come out before finishing the frame.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        send_frame(24);
        for (int i = 0; i < 10; i++)
        begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end
        in_valid <= 1'b0;
        while (cltu_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        send_frame(5);
        drain_cltu();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_tail_modes();
        test_random_frames(0, 0, 25, TAIL_55);
        test_random_frames(67, 0, 25, TAIL_C5_79);
        test_random_frames(0, 67, 25, TAIL_55);
        test_random_frames(18, 18, 25, TAIL_C5_79);
        test_backpressure();

        if (mismatches == 0)
        begin
            $display("ccsds_cltu_encoder_top_test passed");
        end
        else
        begin
            $display("ccsds_cltu_encoder_top_test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("ccsds_cltu_encoder_top_test failed");
        $finish;
    end

endmodule
